// ===== sv/phtu_pkg.sv =====
// Package for the pheromone table update block.
// Command, status and register codes plus parameter defaults; no dependencies.
package phtu_pkg;

    localparam int ROW_COUNT_DEF     = 16;
    localparam int SLOTS_PER_ROW_DEF = 256;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int LVL_W = 32;

    localparam logic [2:0] CMD_LOAD     = 3'd0;
    localparam logic [2:0] CMD_EVAP     = 3'd1;
    localparam logic [2:0] CMD_DEP_ANT  = 3'd2;
    localparam logic [2:0] CMD_DEP_BEST = 3'd3;
    localparam logic [2:0] CMD_READ     = 3'd4;

    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_BADROW = 2'd1;
    localparam logic [1:0] STS_BOUNDS = 2'd2;
    localparam logic [1:0] STS_SAT    = 2'd3;

    localparam logic [1:0] REG_EVAP_RATE = 2'd0;
    localparam logic [1:0] REG_INIT_LVL  = 2'd1;
    localparam logic [1:0] REG_ACTIVE    = 2'd2;

    localparam logic [15:0] EVAP_RATE_RST = 16'd6554;
    localparam logic [31:0] INIT_LVL_RST  = 32'd65536;
    localparam logic [4:0]  ACTIVE_RST    = 5'd16;

endpackage

// ===== sv/phtu_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module phtu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/pheromone_table_update.sv =====
// Pheromone table update: level store in one RAM, row bounds in registers.
// Depends on phtu_pkg and phtu_ram.
//
// Usage: items enter on the s_ channel (command in s_tuser), one result leaves on
// the m_ channel for every item. Registers are to be written over the APB port
// only while the block is idle; the block itself does not enforce this. One item
// is worked on at a time; s_tready is high only in the idle state, while a
// finished result may still sit in the output register. Each division takes
// N = max(34, 2*FRACTION_BITS+2) steps of the shared bit-serial divider (one
// quotient bit a cycle), which sets deposit and load time; the single RAM port
// pair sets the fill and sweep time. Reset clears the row bounds, so every row
// reads as unloaded; a row's slots are written in full by its load before any
// access, so the store needs no clearing pass. When the receiver stalls, the
// result holds in the output register; the next item is still taken and worked
// on, and its result waits until the output register is free.
module pheromone_table_update
    import phtu_pkg::*;
#(
    parameter int ROW_COUNT     = ROW_COUNT_DEF,
    parameter int SLOTS_PER_ROW = SLOTS_PER_ROW_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // param_index[3:0], level_value[35:4], upper_value[67:36], step_size[98:68],
    // fitness[130:99], slot_index[138:131], zero fill
    input  logic [143:0] s_tdata,
    // command[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_level[31:0], used_slot[39:32]
    output logic [39:0]  m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int ROW_W  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int SLOT_W = $clog2(SLOTS_PER_ROW);
    localparam int CNT_W  = $clog2(SLOTS_PER_ROW + 1);
    localparam int EVR_W  = $clog2(ROW_COUNT + 1);
    localparam int DEPTH  = ROW_COUNT * SLOTS_PER_ROW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int NUM_W  = (2 * FRACTION_BITS + 2 > 34) ? 2 * FRACTION_BITS + 2 : 34;
    localparam int DCNT_W = $clog2(NUM_W + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DIV    = 4'd1;
    localparam logic [3:0] ST_FILL   = 4'd2;
    localparam logic [3:0] ST_INC    = 4'd3;
    localparam logic [3:0] ST_DEP_RD = 4'd4;
    localparam logic [3:0] ST_DEP_WR = 4'd5;
    localparam logic [3:0] ST_RD_RD  = 4'd6;
    localparam logic [3:0] ST_RD_WT  = 4'd7;
    localparam logic [3:0] ST_EV_ROW = 4'd8;
    localparam logic [3:0] ST_EV_RD  = 4'd9;
    localparam logic [3:0] ST_EV_WR  = 4'd10;
    localparam logic [3:0] ST_RESP   = 4'd11;

    localparam logic [1:0] PH_LOAD  = 2'd0;
    localparam logic [1:0] PH_QUANT = 2'd1;
    localparam logic [1:0] PH_INC   = 2'd2;

    // input fields
    logic [2:0]  in_cmd;
    logic [3:0]  in_row;
    logic [31:0] in_value, in_upper, in_fit;
    logic [30:0] in_step;
    logic [7:0]  in_slot;
    assign in_cmd   = s_tuser;
    assign in_row   = s_tdata[3:0];
    assign in_value = s_tdata[35:4];
    assign in_upper = s_tdata[67:36];
    assign in_step  = s_tdata[98:68];
    assign in_fit   = s_tdata[130:99];
    assign in_slot  = s_tdata[138:131];

    // configuration
    logic [15:0] rate_reg;
    logic [31:0] init_reg;
    logic [4:0]  active_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg   <= EVAP_RATE_RST;
            init_reg   <= INIT_LVL_RST;
            active_reg <= ACTIVE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_EVAP_RATE: rate_reg   <= pwdata[15:0];
                REG_INIT_LVL:  init_reg   <= pwdata;
                REG_ACTIVE:    active_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_EVAP_RATE: prdata = {16'd0, rate_reg};
            REG_INIT_LVL:  prdata = init_reg;
            REG_ACTIVE:    prdata = {27'd0, active_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // row bounds
    logic [31:0]      row_min_reg [ROW_COUNT];
    logic [30:0]      row_step_reg [ROW_COUNT];
    logic [CNT_W-1:0] row_cnt_reg [ROW_COUNT];

    logic             tbl_we;
    logic [CNT_W-1:0] tbl_cnt;

    // control and datapath registers
    logic [3:0]        state_reg, state_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [31:0]       value_reg, value_next;
    logic [30:0]       step_reg, step_next;
    logic [31:0]       fit_reg, fit_next;
    logic [SLOT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [EVR_W-1:0]  evr_reg, evr_next;
    logic [1:0]        phase_reg, phase_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [32:0]       rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [31:0]       dvsr_reg, dvsr_next;
    logic [31:0]       inc_reg, inc_next;
    logic              sat_reg, sat_next;
    logic [31:0]       res_lvl_reg, res_lvl_next;
    logic [7:0]        res_slot_reg, res_slot_next;
    logic [1:0]        res_sts_reg, res_sts_next;
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_lvl_reg, m_lvl_next;
    logic [7:0]        m_slot_reg, m_slot_next;
    logic [1:0]        m_sts_reg, m_sts_next;

    // memory
    logic              ram_we;
    logic [ADDR_W-1:0] cur_addr;
    logic [31:0]       ram_wdata, ram_rdata;

    assign cur_addr = ADDR_W'(row_reg) * ADDR_W'(SLOTS_PER_ROW) + ADDR_W'(k_reg);

    phtu_ram #(
        .WIDTH(LVL_W),
        .DEPTH(DEPTH)
    ) u_level_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cur_addr),
        .wdata (ram_wdata),
        .raddr (cur_addr),
        .rdata (ram_rdata)
    );

    // restoring divider step
    logic [32:0] div_shift;
    logic        div_ge;
    assign div_shift = {rem_reg[31:0], quo_reg[NUM_W-1]};
    assign div_ge    = div_shift >= {1'b0, dvsr_reg};

    // helpers
    logic             in_row_ok;
    logic [ROW_W-1:0] in_row_i;
    logic [CNT_W-1:0] in_cnt;
    logic [32:0]      dep_d;
    logic [32:0]      load_range;
    logic [EVR_W-1:0] ev_rows;
    logic [16:0]      evap_factor;
    logic [48:0]      evap_prod;
    logic [32:0]      dep_sum;
    logic [CNT_W-1:0] k_ext;

    assign in_row_ok   = 32'(in_row) < ROW_COUNT;
    assign in_row_i    = ROW_W'(in_row);
    assign in_cnt      = row_cnt_reg[in_row_i];
    assign dep_d       = {in_value[31], in_value} - {row_min_reg[in_row_i][31],
                                                     row_min_reg[in_row_i]};
    assign load_range  = {in_upper[31], in_upper} - {in_value[31], in_value};
    assign ev_rows     = (32'(active_reg) < ROW_COUNT) ? EVR_W'(active_reg)
                                                       : EVR_W'(ROW_COUNT);
    assign evap_factor = 17'h10000 - {1'b0, rate_reg};
    assign evap_prod   = ram_rdata * evap_factor;
    assign dep_sum     = {1'b0, ram_rdata} + {1'b0, inc_reg};
    assign k_ext       = CNT_W'(k_reg);

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        row_next      = row_reg;
        value_next    = value_reg;
        step_next     = step_reg;
        fit_next      = fit_reg;
        k_next        = k_reg;
        cnt_next      = cnt_reg;
        evr_next      = evr_reg;
        phase_next    = phase_reg;
        dcnt_next     = dcnt_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dvsr_next     = dvsr_reg;
        inc_next      = inc_reg;
        sat_next      = sat_reg;
        res_lvl_next  = res_lvl_reg;
        res_slot_next = res_slot_reg;
        res_sts_next  = res_sts_reg;
        m_valid_next  = m_valid_reg & ~m_tready;
        m_lvl_next    = m_lvl_reg;
        m_slot_next   = m_slot_reg;
        m_sts_next    = m_sts_reg;
        ram_we        = 1'b0;
        ram_wdata     = 32'd0;
        tbl_we        = 1'b0;
        tbl_cnt       = cnt_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next      = in_cmd;
                    row_next      = in_row_i;
                    value_next    = in_value;
                    step_next     = in_step;
                    fit_next      = in_fit;
                    cnt_next      = in_cnt;
                    sat_next      = 1'b0;
                    res_lvl_next  = 32'd0;
                    res_slot_next = 8'd0;
                    res_sts_next  = STS_OK;
                    state_next    = ST_RESP;
                    if (in_cmd == CMD_EVAP) begin
                        evr_next   = '0;
                        state_next = ST_EV_ROW;
                    end else if (in_cmd != CMD_LOAD && in_cmd != CMD_DEP_ANT &&
                                 in_cmd != CMD_DEP_BEST && in_cmd != CMD_READ) begin
                        state_next = ST_RESP;
                    end else if (!in_row_ok) begin
                        res_sts_next = STS_BADROW;
                    end else if (in_cmd == CMD_LOAD) begin
                        if (in_step == 31'd0 || load_range[32]) begin
                            res_sts_next = STS_BOUNDS;
                        end else begin
                            phase_next = PH_LOAD;
                            dcnt_next  = DCNT_W'(NUM_W);
                            rem_next   = '0;
                            quo_next   = NUM_W'(load_range[31:0]);
                            dvsr_next  = {1'b0, in_step};
                            state_next = ST_DIV;
                        end
                    end else if (in_cnt == '0) begin
                        res_sts_next = STS_BADROW;
                    end else if (in_cmd == CMD_READ) begin
                        res_slot_next = in_slot;
                        if (CNT_W'(32'(in_slot)) >= in_cnt || 32'(in_slot) >= SLOTS_PER_ROW) begin
                            res_sts_next = STS_BADROW;
                        end else begin
                            k_next     = SLOT_W'(in_slot);
                            state_next = ST_RD_RD;
                        end
                    end else if (dep_d[32]) begin
                        // below the row minimum: first slot
                        k_next     = '0;
                        state_next = ST_INC;
                    end else begin
                        phase_next = PH_QUANT;
                        dcnt_next  = DCNT_W'(NUM_W);
                        rem_next   = '0;
                        quo_next   = NUM_W'({dep_d[31:0], 1'b0})
                                   + NUM_W'(row_step_reg[in_row_i]);
                        dvsr_next  = {row_step_reg[in_row_i], 1'b0};
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV: begin
                if (dcnt_reg != '0) begin
                    rem_next  = div_ge ? div_shift - {1'b0, dvsr_reg} : div_shift;
                    quo_next  = {quo_reg[NUM_W-2:0], div_ge};
                    dcnt_next = dcnt_reg - DCNT_W'(1);
                end else begin
                    unique case (phase_reg)
                        PH_LOAD: begin
                            if (quo_reg >= NUM_W'(SLOTS_PER_ROW)) begin
                                cnt_next = CNT_W'(SLOTS_PER_ROW);
                            end else begin
                                cnt_next = CNT_W'(quo_reg) + CNT_W'(1);
                            end
                            tbl_we     = 1'b1;
                            tbl_cnt    = cnt_next;
                            k_next     = '0;
                            state_next = ST_FILL;
                        end
                        PH_QUANT: begin
                            if (quo_reg > NUM_W'(cnt_reg - CNT_W'(1))) begin
                                k_next = SLOT_W'(cnt_reg - CNT_W'(1));
                            end else begin
                                k_next = SLOT_W'(quo_reg);
                            end
                            state_next = ST_INC;
                        end
                        default: begin
                            if (quo_reg[NUM_W-1:32] != '0) begin
                                inc_next = 32'hFFFF_FFFF;
                                sat_next = 1'b1;
                            end else begin
                                inc_next = quo_reg[31:0];
                            end
                            state_next = ST_DEP_RD;
                        end
                    endcase
                end
            end

            ST_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = (k_ext < cnt_reg) ? init_reg : 32'd0;
                k_next    = k_reg + SLOT_W'(1);
                if (k_reg == SLOT_W'(SLOTS_PER_ROW - 1)) begin
                    state_next = ST_RESP;
                end
            end

            ST_INC: begin
                if (fit_reg == 32'd0) begin
                    inc_next   = 32'hFFFF_FFFF;
                    sat_next   = 1'b1;
                    state_next = ST_DEP_RD;
                end else begin
                    phase_next = PH_INC;
                    dcnt_next  = DCNT_W'(NUM_W);
                    rem_next   = '0;
                    quo_next   = NUM_W'(1) << (2 * FRACTION_BITS
                                 + ((cmd_reg == CMD_DEP_BEST) ? 1 : 0));
                    dvsr_next  = fit_reg;
                    state_next = ST_DIV;
                end
            end

            ST_DEP_RD: state_next = ST_DEP_WR;

            ST_DEP_WR: begin
                ram_we        = 1'b1;
                ram_wdata     = dep_sum[32] ? 32'hFFFF_FFFF : dep_sum[31:0];
                res_lvl_next  = ram_wdata;
                res_slot_next = 8'(k_reg);
                res_sts_next  = (sat_reg | dep_sum[32]) ? STS_SAT : STS_OK;
                state_next    = ST_RESP;
            end

            ST_RD_RD: state_next = ST_RD_WT;

            ST_RD_WT: begin
                res_lvl_next = ram_rdata;
                state_next   = ST_RESP;
            end

            ST_EV_ROW: begin
                if (evr_reg >= ev_rows) begin
                    state_next = ST_RESP;
                end else if (row_cnt_reg[ROW_W'(evr_reg)] == '0) begin
                    evr_next = evr_reg + EVR_W'(1);
                end else begin
                    row_next   = ROW_W'(evr_reg);
                    cnt_next   = row_cnt_reg[ROW_W'(evr_reg)];
                    k_next     = '0;
                    state_next = ST_EV_RD;
                end
            end

            ST_EV_RD: state_next = ST_EV_WR;

            ST_EV_WR: begin
                ram_we    = 1'b1;
                ram_wdata = evap_prod[47:16];
                if (k_ext + CNT_W'(1) >= cnt_reg) begin
                    evr_next   = evr_reg + EVR_W'(1);
                    state_next = ST_EV_ROW;
                end else begin
                    k_next     = k_reg + SLOT_W'(1);
                    state_next = ST_EV_RD;
                end
            end

            ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_lvl_next   = res_lvl_reg;
                    m_slot_next  = res_slot_reg;
                    m_sts_next   = res_sts_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < ROW_COUNT; i++) begin
                row_min_reg[i]  <= '0;
                row_step_reg[i] <= '0;
                row_cnt_reg[i]  <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (tbl_we) begin
                row_min_reg[row_reg]  <= value_reg;
                row_step_reg[row_reg] <= step_reg;
                row_cnt_reg[row_reg]  <= tbl_cnt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        row_reg      <= row_next;
        value_reg    <= value_next;
        step_reg     <= step_next;
        fit_reg      <= fit_next;
        k_reg        <= k_next;
        cnt_reg      <= cnt_next;
        evr_reg      <= evr_next;
        phase_reg    <= phase_next;
        dcnt_reg     <= dcnt_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dvsr_reg     <= dvsr_next;
        inc_reg      <= inc_next;
        sat_reg      <= sat_next;
        res_lvl_reg  <= res_lvl_next;
        res_slot_reg <= res_slot_next;
        res_sts_reg  <= res_sts_next;
        m_lvl_reg    <= m_lvl_next;
        m_slot_reg   <= m_slot_next;
        m_sts_reg    <= m_sts_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_slot_reg, m_lvl_reg};
    assign m_tuser  = m_sts_reg;

`ifndef SYNTHESIS
    ap_ev_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EV_WR |-> $past(state_reg) == ST_EV_RD)
        else $error("evaporation write without a preceding read");

    ap_dep_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DEP_WR |-> k_ext < cnt_reg)
        else $error("deposit slot beyond row count");

    ap_tbl_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_we |-> (tbl_cnt != '0 && 32'(tbl_cnt) <= SLOTS_PER_ROW))
        else $error("row count out of range on load");

    ap_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RESP && (!m_valid_reg || m_tready)
        |=> state_reg == ST_IDLE && m_valid_reg)
        else $error("result not presented");
`endif

endmodule
